// ===== rtl/lshc_pkg.sv =====
// Shared types and constants of the shader handle cache.
package lshc_pkg;

   // Field widths fixed by the item and result formats.
   localparam int MODE_W     = 5;
   localparam int HANDLE_W   = 16;
   localparam int COUNT_W    = 6;
   localparam int ALIAS_W    = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 6;

   // Handle value that marks "no program".
   localparam logic [HANDLE_W-1:0] NO_HANDLE = 16'hFFFF;

   // Reset value of the legal mode count.
   localparam logic [COUNT_W-1:0] MODE_COUNT_RESET = 6'd17;

   // Item action codes.
   localparam logic ACT_REGISTER = 1'b0;
   localparam logic ACT_LOOKUP   = 1'b1;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE_COUNT  = 1'b1;

   typedef enum logic [2:0] {
      OUT_HIT          = 3'd0,
      OUT_PAL_FALLBACK = 3'd1,
      OUT_ALIAS_NORMAL = 3'd2,
      OUT_ALIAS_OTHER  = 3'd3,
      OUT_MISS         = 3'd4,
      OUT_REGISTERED   = 3'd5,
      OUT_REJECTED     = 3'd6
   } outcome_type;

   // How the age ranks change once the search is done.
   typedef enum logic [1:0] {
      UPD_NONE   = 2'd0,
      UPD_RECENT = 2'd1,
      UPD_INSERT = 2'd2
   } upd_type;

   typedef enum logic [2:0] {
      ST_IDLE       = 3'd0,
      ST_SCAN       = 3'd1,
      ST_SCAN_WAIT  = 3'd2,
      ST_DECIDE     = 3'd3,
      ST_SWEEP      = 3'd4,
      ST_SWEEP_WAIT = 3'd5
   } state_type;

   typedef struct packed {
      logic                action;
      logic [MODE_W-1:0]   blend_mode;
      logic                use_palette;
      logic [HANDLE_W-1:0] program_handle;
   } req_type;

   typedef struct packed {
      logic [HANDLE_W-1:0] result_handle;
      outcome_type         outcome;
      logic                evicted_valid;
      logic [HANDLE_W-1:0] evicted_handle;
      logic [ALIAS_W-1:0]  alias_total;
   } rsp_type;

   // One stored entry apart from its age rank.
   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic                palette;
      logic [HANDLE_W-1:0] handle;
   } entry_data_type;

   // Decision of the search unit for the current item.
   typedef struct packed {
      upd_type             upd;
      logic                evict;
      outcome_type         outcome;
      logic [HANDLE_W-1:0] result_handle;
      logic [HANDLE_W-1:0] evict_handle;
      logic [HANDLE_W-1:0] wr_handle;
      logic                ins_palette;
      logic                alias_bump;
   } plan_type;

endpackage

// ===== rtl/lshc_entry_ram.sv =====
// Entry storage: key, handle and age rank per slot, one write and one registered read port.
module lshc_entry_ram
   #(parameter int ENTRIES = 16,
     localparam int IdxW = $clog2(ENTRIES))
   (input  logic                       clock,
    input  logic [IdxW-1:0]            rd_addr,
    output lshc_pkg::entry_data_type   rd_data,
    output logic [IdxW-1:0]            rd_rank,
    input  logic [IdxW-1:0]            wr_addr,
    input  logic                       wr_data_en,
    input  lshc_pkg::entry_data_type   wr_data,
    input  logic                       wr_rank_en,
    input  logic [IdxW-1:0]            wr_rank);

   import lshc_pkg::*;

   entry_data_type  data_mem_ff [ENTRIES];
   logic [IdxW-1:0] rank_mem_ff [ENTRIES];
   entry_data_type  rd_data_ff;
   logic [IdxW-1:0] rd_rank_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_data_en) begin
         data_mem_ff[wr_addr] <= wr_data;
      end
      if (wr_rank_en) begin
         rank_mem_ff[wr_addr] <= wr_rank;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rd_data_ff <= data_mem_ff[rd_addr];
      rd_rank_ff <= rank_mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign rd_rank = rd_rank_ff;

endmodule

// ===== rtl/lshc_search.sv =====
// Search unit: compares one streamed entry per cycle and decides what the item does.
module lshc_search
   #(parameter int ENTRIES = 16,
     localparam int IdxW = $clog2(ENTRIES),
     localparam int CntW = $clog2(ENTRIES + 1))
   (input  logic                     clock,
    input  logic                     reset,
    input  logic                     clear,
    input  logic                     acc_en,
    input  logic [IdxW-1:0]          slot,
    input  logic                     slot_valid,
    input  lshc_pkg::entry_data_type entry,
    input  logic [IdxW-1:0]          entry_rank,
    input  lshc_pkg::req_type        key,
    input  logic [4:0]               normal_mode,
    input  logic [5:0]               mode_count,
    output lshc_pkg::plan_type       plan,
    output logic [IdxW-1:0]          tgt_slot,
    output logic [IdxW-1:0]          tgt_rank,
    output logic [IdxW-1:0]          evict_slot);

   import lshc_pkg::*;

   // Candidates found during the scan.
   logic                hit_ff, fb_ff, nrm_ff, oth1_ff, oth2_ff, old_ff, free_ff;
   logic [IdxW-1:0]     hit_slot_ff, fb_slot_ff, nrm_slot_ff, oth1_slot_ff;
   logic [IdxW-1:0]     old_slot_ff, free_slot_ff;
   logic [IdxW-1:0]     hit_rank_ff, fb_rank_ff, old_rank_ff;
   logic [HANDLE_W-1:0] hit_handle_ff, fb_handle_ff, nrm_handle_ff;
   logic [HANDLE_W-1:0] oth1_handle_ff, oth2_handle_ff, old_handle_ff;
   logic [CntW-1:0]     cnt_ff;

   logic is_hit, is_fb, is_nrm, is_oth, is_older;
   logic full, legal, fb_ok, nrm_ok, oth1_ok, oth_ok;
   logic [IdxW-1:0]     ins_slot;
   logic [HANDLE_W-1:0] oth_handle;

   // Compares on the entry streamed in this cycle.
   always_comb begin
      is_hit   = slot_valid && (entry.mode == key.blend_mode)
                 && (entry.palette == key.use_palette);
      is_fb    = slot_valid && (entry.mode == key.blend_mode) && !entry.palette;
      is_nrm   = slot_valid && (entry.mode == normal_mode) && !entry.palette;
      is_oth   = slot_valid && !entry.palette;
      is_older = slot_valid && (!old_ff || (entry_rank > old_rank_ff));
   end

   // Accumulate the lowest matching slots, the live count and the oldest entry.
   always_ff @(posedge clock) begin
      if (reset || clear) begin
         hit_ff  <= 1'b0;
         fb_ff   <= 1'b0;
         nrm_ff  <= 1'b0;
         oth1_ff <= 1'b0;
         oth2_ff <= 1'b0;
         old_ff  <= 1'b0;
         free_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (acc_en) begin
         if (slot_valid) begin
            cnt_ff <= cnt_ff + CntW'(1);
         end
         if (is_hit && !hit_ff) begin
            hit_ff        <= 1'b1;
            hit_slot_ff   <= slot;
            hit_rank_ff   <= entry_rank;
            hit_handle_ff <= entry.handle;
         end
         if (is_fb && !fb_ff) begin
            fb_ff        <= 1'b1;
            fb_slot_ff   <= slot;
            fb_rank_ff   <= entry_rank;
            fb_handle_ff <= entry.handle;
         end
         if (is_nrm && !nrm_ff) begin
            nrm_ff        <= 1'b1;
            nrm_slot_ff   <= slot;
            nrm_handle_ff <= entry.handle;
         end
         if (is_oth && !oth1_ff) begin
            oth1_ff        <= 1'b1;
            oth1_slot_ff   <= slot;
            oth1_handle_ff <= entry.handle;
         end else if (is_oth && !oth2_ff) begin
            oth2_ff        <= 1'b1;
            oth2_handle_ff <= entry.handle;
         end
         if (is_older) begin
            old_ff        <= 1'b1;
            old_slot_ff   <= slot;
            old_rank_ff   <= entry_rank;
            old_handle_ff <= entry.handle;
         end
         if (!slot_valid && !free_ff) begin
            free_ff      <= 1'b1;
            free_slot_ff <= slot;
         end
      end
   end

   // A miss on a full cache evicts the oldest entry, which then no longer counts as a target.
   always_comb begin
      full     = (cnt_ff == CntW'(ENTRIES)) && old_ff;
      legal    = {1'b0, key.blend_mode} < mode_count;
      fb_ok    = fb_ff && !(full && (fb_slot_ff == old_slot_ff));
      nrm_ok   = nrm_ff && !(full && (nrm_slot_ff == old_slot_ff));
      oth1_ok  = oth1_ff && !(full && (oth1_slot_ff == old_slot_ff));
      oth_ok   = oth1_ok || oth2_ff;
      oth_handle = oth1_ok ? oth1_handle_ff : oth2_handle_ff;
      ins_slot = full ? old_slot_ff : free_slot_ff;
   end

   // Decision for the item once the scan is complete.
   always_comb begin
      plan               = '0;
      plan.upd           = UPD_NONE;
      plan.outcome       = OUT_MISS;
      plan.result_handle = NO_HANDLE;
      tgt_slot           = ins_slot;
      tgt_rank           = '0;
      if (key.action == ACT_REGISTER) begin
         plan.result_handle = key.program_handle;
         if (key.program_handle == NO_HANDLE) begin
            plan.outcome = OUT_REJECTED;
         end else begin
            plan.outcome   = OUT_REGISTERED;
            plan.wr_handle = key.program_handle;
            if (hit_ff) begin
               plan.upd = UPD_RECENT;
               tgt_slot = hit_slot_ff;
               tgt_rank = hit_rank_ff;
            end else begin
               plan.evict       = full;
               plan.upd         = UPD_INSERT;
               plan.ins_palette = key.use_palette;
            end
         end
      end else if (hit_ff) begin
         plan.outcome       = OUT_HIT;
         plan.result_handle = hit_handle_ff;
         plan.wr_handle     = hit_handle_ff;
         plan.upd           = UPD_RECENT;
         tgt_slot           = hit_slot_ff;
         tgt_rank           = hit_rank_ff;
      end else begin
         plan.evict = full;
         if (key.use_palette) begin
            // Palette miss falls back to the plain variant of the same mode.
            if (fb_ok) begin
               plan.outcome       = OUT_PAL_FALLBACK;
               plan.result_handle = fb_handle_ff;
               plan.wr_handle     = fb_handle_ff;
               plan.upd           = UPD_RECENT;
               tgt_slot           = fb_slot_ff;
               tgt_rank           = fb_rank_ff;
            end
         end else begin
            // Plain miss aliases to the Normal entry, else, for a legal mode, to the lowest plain entry.
            if (nrm_ok) begin
               plan.outcome       = OUT_ALIAS_NORMAL;
               plan.result_handle = nrm_handle_ff;
            end else if (legal && oth_ok) begin
               plan.outcome       = OUT_ALIAS_OTHER;
               plan.result_handle = oth_handle;
            end
            if (nrm_ok || (legal && oth_ok)) begin
               plan.upd         = UPD_INSERT;
               plan.wr_handle   = plan.result_handle;
               plan.ins_palette = 1'b0;
               plan.alias_bump  = legal;
            end
         end
      end
      plan.evict_handle = plan.evict ? old_handle_ff : '0;
   end

   assign evict_slot = old_slot_ff;

endmodule

// ===== rtl/lru_shader_handle_cache.sv =====
// Top level of the LRU shader handle cache: sequencer, configuration and result register.
//
// Usage: an item (register or lookup of a blend mode and palette key) is transferred
// at a rising edge with start high and busy low; busy then stays high until the item
// is done. Each item gives one result on rsp_data, marked by rsp_valid for exactly one
// cycle; the receiver takes it at the end of that cycle and cannot hold it off.
// Configuration (normal mode, legal mode count) is written on the csr_ channel,
// which is always ready; write it only while no item is in progress.
// Operation: one pass over the entry memory, one read per cycle, feeds the shared
// search unit; an item that changes the age ranks takes a second pass that rewrites,
// through the memory's single write port, each rank that changes. The result strobe
// falls in the first cycle in which the next item can be transferred.
// Reset clears all valid bits and the alias counter and sets the configuration registers
// to their reset values; entry contents are not cleared and need no clearing pass.
module lru_shader_handle_cache
   #(parameter int CACHE_ENTRIES = 16)
   (input  logic                                    clock,
    input  logic                                    reset,
    input  logic                                    start,
    output logic                                    busy,
    input  lshc_pkg::req_type                       req_data,
    output logic                                    rsp_valid,
    output lshc_pkg::rsp_type                       rsp_data,
    input  logic                                    csr_valid,
    output logic                                    csr_ready,
    input  logic [lshc_pkg::CSR_IDX_W-1:0]          csr_index,
    input  logic [lshc_pkg::CSR_DATA_W-1:0]         csr_data);

   import lshc_pkg::*;

   localparam int IdxW = $clog2(CACHE_ENTRIES);

   state_type            state_ff, state_in;
   logic [IdxW-1:0]      idx_ff, idx_in;
   logic                 pipe_vld_ff;
   logic [IdxW-1:0]      pipe_tag_ff;
   req_type              item_ff;
   logic [MODE_W-1:0]    normal_mode_ff;
   logic [COUNT_W-1:0]   mode_count_ff;
   logic [ALIAS_W-1:0]   alias_ff, alias_in;
   logic [CACHE_ENTRIES-1:0] valid_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic accept, issue, acc_en, sweep_wr, finish, last_idx, tag_live;

   entry_data_type  rd_data, wr_data;
   logic [IdxW-1:0] rd_rank, wr_rank;
   logic            wr_data_en, wr_rank_en;

   plan_type        plan;
   logic [IdxW-1:0] tgt_slot, tgt_rank, evict_slot;

   lshc_entry_ram #(.ENTRIES(CACHE_ENTRIES)) u_ram (
      .clock      (clock),
      .rd_addr    (idx_ff),
      .rd_data    (rd_data),
      .rd_rank    (rd_rank),
      .wr_addr    (pipe_tag_ff),
      .wr_data_en (wr_data_en),
      .wr_data    (wr_data),
      .wr_rank_en (wr_rank_en),
      .wr_rank    (wr_rank));

   lshc_search #(.ENTRIES(CACHE_ENTRIES)) u_search (
      .clock       (clock),
      .reset       (reset),
      .clear       (accept),
      .acc_en      (acc_en),
      .slot        (pipe_tag_ff),
      .slot_valid  (valid_ff[pipe_tag_ff]),
      .entry       (rd_data),
      .entry_rank  (rd_rank),
      .key         (item_ff),
      .normal_mode (normal_mode_ff),
      .mode_count  (mode_count_ff),
      .plan        (plan),
      .tgt_slot    (tgt_slot),
      .tgt_rank    (tgt_rank),
      .evict_slot  (evict_slot));

   assign last_idx = (idx_ff == IdxW'(CACHE_ENTRIES - 1));

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (last_idx) state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            state_in = (plan.upd == UPD_NONE) ? ST_IDLE : ST_SWEEP;
         end
         ST_SWEEP: begin
            if (last_idx) state_in = ST_SWEEP_WAIT;
         end
         ST_SWEEP_WAIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      busy     = 1'b1;
      accept   = 1'b0;
      issue    = 1'b0;
      acc_en   = 1'b0;
      sweep_wr = 1'b0;
      finish   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            busy   = 1'b0;
            accept = start;
         end
         ST_SCAN: begin
            issue  = 1'b1;
            acc_en = pipe_vld_ff;
         end
         ST_SCAN_WAIT: begin
            acc_en = pipe_vld_ff;
         end
         ST_DECIDE: begin
            finish = (plan.upd == UPD_NONE);
         end
         ST_SWEEP: begin
            issue    = 1'b1;
            sweep_wr = pipe_vld_ff;
         end
         ST_SWEEP_WAIT: begin
            sweep_wr = pipe_vld_ff;
            finish   = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Slot counter shared by the scan and the rank sweep.
   always_comb begin
      idx_in = idx_ff;
      if (accept || (state_ff == ST_DECIDE)) begin
         idx_in = '0;
      end else if (issue) begin
         idx_in = idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         pipe_vld_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         pipe_vld_ff <= issue;
      end
   end

   // The slot tag follows the registered read data.
   always_ff @(posedge clock) begin
      pipe_tag_ff <= idx_ff;
      if (accept) begin
         item_ff <= req_data;
      end
   end

   // Rank sweep: the target goes to rank zero, live entries age as the update requires.
   assign tag_live = valid_ff[pipe_tag_ff] && !(plan.evict && (pipe_tag_ff == evict_slot));

   always_comb begin
      wr_data_en = 1'b0;
      wr_rank_en = 1'b0;
      wr_data    = rd_data;
      wr_rank    = rd_rank;
      if (sweep_wr) begin
         if (pipe_tag_ff == tgt_slot) begin
            wr_data_en     = 1'b1;
            wr_rank_en     = 1'b1;
            wr_rank        = '0;
            wr_data.handle = plan.wr_handle;
            if (plan.upd == UPD_INSERT) begin
               wr_data.mode    = item_ff.blend_mode;
               wr_data.palette = plan.ins_palette;
            end
         end else if (tag_live && ((plan.upd == UPD_INSERT) || (rd_rank < tgt_rank))) begin
            wr_rank_en = 1'b1;
            wr_rank    = rd_rank + IdxW'(1);
         end
      end
   end

   // Valid bits change only when the item completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (finish) begin
         if (plan.evict) begin
            valid_ff[evict_slot] <= 1'b0;
         end
         if (plan.upd == UPD_INSERT) begin
            valid_ff[tgt_slot] <= 1'b1;
         end
      end
   end

   // Configuration registers.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         normal_mode_ff <= '0;
         mode_count_ff  <= MODE_COUNT_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_NORMAL_MODE: normal_mode_ff <= csr_data[MODE_W-1:0];
            CSR_MODE_COUNT:  mode_count_ff  <= csr_data[COUNT_W-1:0];
            default: begin
               normal_mode_ff <= normal_mode_ff;
            end
         endcase
      end
   end

   // Saturating alias counter and the result register.
   always_comb begin
      alias_in = alias_ff;
      if (finish && plan.alias_bump && (alias_ff != '1)) begin
         alias_in = alias_ff + ALIAS_W'(1);
      end
      rsp_data_in.result_handle  = plan.result_handle;
      rsp_data_in.outcome        = plan.outcome;
      rsp_data_in.evicted_valid  = plan.evict;
      rsp_data_in.evicted_handle = plan.evict_handle;
      rsp_data_in.alias_total    = alias_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alias_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         alias_ff     <= alias_in;
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A result is only shown once the block is free again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while an item is in progress");

   // Exactly one result per item: no strobe right after a transfer or after a strobe.
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid || accept) |=> !rsp_valid)
      else $error("result strobe repeated or too early");

   // Eviction happens only on a full cache.
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (finish && plan.evict) |-> ($countones(valid_ff) == CACHE_ENTRIES))
      else $error("eviction from a cache that is not full");

   // An insertion goes to a free slot or to the slot just evicted.
   a_insert_free: assert property (@(posedge clock) disable iff (reset)
      (finish && (plan.upd == UPD_INSERT)) |->
         (!valid_ff[tgt_slot] || (plan.evict && (tgt_slot == evict_slot))))
      else $error("insertion over a live entry");

endmodule
